// ----- rtl/adl_pkg.sv -----
// Shared types and constants for the adjacent duplicate line filter.
// No dependencies; adl_front, adl_back and the top level refer to this package by scoped names.
package adl_pkg;

	localparam logic [7:0] NEWLINE = 8'h0A;
	localparam int COUNT_W = 32;

	// Configuration register indexes.
	localparam int CFG_INDEX_W = 2;
	localparam logic [CFG_INDEX_W-1:0] REG_ONLY_REPEATED = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_ONLY_SINGLE   = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_SHOW_COUNT    = 2'd2;

	// Finished runs waiting between the front and the back.
	localparam int RUN_QUEUE_DEPTH = 2;
	// One bank each for the line being built and the previous line, one for
	// the run being emitted, and one per queued run.
	localparam int NUM_BANKS = RUN_QUEUE_DEPTH + 3;
	localparam int BANK_W = $clog2(NUM_BANKS);

	localparam int OUT_FIFO_DEPTH = 4;
	localparam int OUT_W = 8 + COUNT_W + 1;

	typedef struct packed {
		logic only_repeated;
		logic only_single;
		logic show_count;
	} adl_cfg_t;

	// Back tells the front that a line bank has been read out completely.
	typedef struct packed {
		logic              valid;
		logic [BANK_W-1:0] bank;
	} adl_release_t;

endpackage

// ----- rtl/adl_fifo.sv -----
// Small register FIFO used for the run queue and the result queue.
// Depends on nothing but its parameters.
module adl_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  logic [WIDTH-1:0]           din,
	output logic                       full,
	input  logic                       pop,
	output logic [WIDTH-1:0]           dout,
	output logic                       empty,
	output logic [$clog2(DEPTH+1)-1:0] level
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] store_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    cnt_q;
	logic             do_push;
	logic             do_pop;

	always_comb begin
		full    = cnt_q == CW'(DEPTH);
		empty   = cnt_q == '0;
		level   = cnt_q;
		dout    = store_q[rd_ptr_q];
		do_push = push && !full;
		do_pop  = pop && !empty;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			store_q[wr_ptr_q] <= din;
		end
	end

endmodule

// ----- rtl/adl_linebuf.sv -----
// Banked line storage: one write port and two registered read ports.
// Depends on nothing but its parameters; address is {bank, byte index}.
module adl_linebuf #(
	parameter int AW    = 8,
	parameter int DEPTH = 160
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [7:0]    wdata,
	input  logic [AW-1:0] raddr_a,
	output logic [7:0]    rdata_a,
	input  logic [AW-1:0] raddr_b,
	output logic [7:0]    rdata_b
);

	logic [7:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

// ----- rtl/adl_front.sv -----
// Front end: accepts bytes, builds lines, compares them with the previous line
// and queues finished runs. Depends on adl_pkg.
module adl_front #(
	parameter int LINE_MAX = 32,
	parameter int LW       = $clog2(LINE_MAX),
	parameter int AW       = adl_pkg::BANK_W + LW
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	output logic                        full,
	input  logic                        operation,
	input  logic [7:0]                  data_byte,
	input  adl_pkg::adl_cfg_t           cfg,
	output logic                        mem_we,
	output logic [AW-1:0]               mem_waddr,
	output logic [AW-1:0]               mem_raddr,
	input  logic [7:0]                  mem_rdata,
	output logic                        rq_push,
	input  logic                        rq_full,
	output logic [adl_pkg::BANK_W-1:0]  rq_bank,
	output logic [LW-1:0]               rq_len,
	output logic [adl_pkg::COUNT_W-1:0] rq_count,
	input  adl_pkg::adl_release_t       rel
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_CMP   = 2'd1;
	localparam logic [1:0] ST_FLUSH = 2'd2;

	localparam int BW = adl_pkg::BANK_W;
	localparam int CNW = adl_pkg::COUNT_W;

	logic [1:0]                  state_q;
	logic [BW-1:0]               cur_bank_q;
	logic [BW-1:0]               prev_bank_q;
	logic [LW-1:0]               cur_len_q;
	logic [LW-1:0]               prev_len_q;
	logic                        prev_valid_q;
	logic [CNW-1:0]              count_q;
	logic                        match_q;
	logic [adl_pkg::NUM_BANKS-1:0] busy_q;
	logic [7:0]                  byte_s1;

	logic                        accept;
	logic                        is_nl;
	logic                        at_limit;
	logic                        same;
	logic                        run_pass;
	logic                        close_line;
	logic                        store;
	logic                        flush_done;
	logic [BW-1:0]               free_bank;
	logic [BW-1:0]               new_cur;
	logic [BW-1:0]               new_prev;
	logic [adl_pkg::NUM_BANKS-1:0] busy_nxt;

	always_comb begin
		full     = (state_q != ST_IDLE) || rq_full;
		accept   = push && !full;
		is_nl    = data_byte == adl_pkg::NEWLINE;
		at_limit = cur_len_q == LW'(LINE_MAX - 1);
		// All byte compares of the open line have finished by the time it closes.
		same     = prev_valid_q && (prev_len_q == cur_len_q) && match_q;
		run_pass = !(cfg.only_repeated && (count_q < CNW'(2))) &&
		           !(cfg.only_single && (count_q > CNW'(1)));
		close_line = accept && (operation ? (cur_len_q != '0) : (is_nl || at_limit));
		store      = accept && !operation && !is_nl;
		flush_done = (state_q == ST_FLUSH) && !rq_full;

		free_bank = '0;
		for (int i = adl_pkg::NUM_BANKS - 1; i >= 0; i--) begin
			if (!busy_q[i] && (BW'(i) != cur_bank_q) && (BW'(i) != prev_bank_q)) begin
				free_bank = BW'(i);
			end
		end
		new_cur  = same ? cur_bank_q : free_bank;
		new_prev = same ? prev_bank_q : cur_bank_q;

		// A cut line starts the new one at index 0 of the bank it now owns.
		mem_we    = store;
		mem_waddr = close_line ? {new_cur, LW'(0)} : {cur_bank_q, cur_len_q};
		mem_raddr = close_line ? {new_prev, LW'(0)} : {prev_bank_q, cur_len_q};

		rq_push  = prev_valid_q && run_pass &&
		           ((close_line && !same) || flush_done);
		rq_bank  = prev_bank_q;
		rq_len   = prev_len_q;
		rq_count = cfg.show_count ? count_q : '0;

		busy_nxt = busy_q;
		if (rel.valid) begin
			busy_nxt[rel.bank] = 1'b0;
		end
		if (rq_push) begin
			busy_nxt[prev_bank_q] = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			cur_bank_q   <= BW'(0);
			prev_bank_q  <= BW'(1);
			cur_len_q    <= '0;
			prev_len_q   <= '0;
			prev_valid_q <= 1'b0;
			count_q      <= '0;
			match_q      <= 1'b1;
			busy_q       <= '0;
		end else begin
			busy_q <= busy_nxt;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (close_line) begin
							match_q <= 1'b1;
							if (same) begin
								if (count_q != '1) begin
									count_q <= count_q + CNW'(1);
								end
							end else begin
								prev_bank_q  <= cur_bank_q;
								cur_bank_q   <= free_bank;
								prev_len_q   <= cur_len_q;
								prev_valid_q <= 1'b1;
								count_q      <= CNW'(1);
							end
						end
						if (operation) begin
							cur_len_q <= '0;
							state_q   <= ST_FLUSH;
						end else if (close_line) begin
							cur_len_q <= is_nl ? LW'(0) : LW'(1);
						end else begin
							cur_len_q <= cur_len_q + LW'(1);
						end
						if (store) begin
							state_q <= ST_CMP;
						end
					end
				end
				ST_CMP: begin
					match_q <= match_q && (mem_rdata == byte_s1);
					state_q <= ST_IDLE;
				end
				ST_FLUSH: begin
					if (!rq_full) begin
						prev_valid_q <= 1'b0;
						prev_len_q   <= '0;
						count_q      <= '0;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (store) begin
			byte_s1 <= data_byte;
		end
	end

endmodule

// ----- rtl/adl_back.sv -----
// Back end: takes queued runs, reads their line bytes out of the line buffer
// and delivers results through the output queue. Depends on adl_pkg and adl_fifo.
module adl_back #(
	parameter int LINE_MAX = 32,
	parameter int LW       = $clog2(LINE_MAX),
	parameter int AW       = adl_pkg::BANK_W + LW
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        rq_empty,
	output logic                        rq_pop,
	input  logic [adl_pkg::BANK_W-1:0]  rq_bank,
	input  logic [LW-1:0]               rq_len,
	input  logic [adl_pkg::COUNT_W-1:0] rq_count,
	output logic [AW-1:0]               mem_raddr,
	input  logic [7:0]                  mem_rdata,
	output adl_pkg::adl_release_t       rel,
	output logic                        empty,
	input  logic                        pop,
	output logic [7:0]                  out_byte,
	output logic [adl_pkg::COUNT_W-1:0] run_count,
	output logic                        line_end
);

	localparam int OCW = $clog2(adl_pkg::OUT_FIFO_DEPTH + 1);
	localparam int OFW = OCW + 1;

	logic                        active_q;
	logic [adl_pkg::BANK_W-1:0]  bank_q;
	logic [LW-1:0]               len_q;
	logic [LW-1:0]               idx_q;
	logic [adl_pkg::COUNT_W-1:0] cnt_q;
	logic                        valid_s1;
	logic                        nl_s1;
	logic [adl_pkg::COUNT_W-1:0] cnt_s1;

	logic                        room;
	logic                        issue;
	logic                        at_end;
	logic [OCW-1:0]              of_level;
	logic                        of_full;
	logic [adl_pkg::OUT_W-1:0]   of_din;
	logic [adl_pkg::OUT_W-1:0]   of_dout;

	always_comb begin
		rq_pop = !active_q && !rq_empty;
		// Count the byte still in the read stage so the result queue never overflows.
		room   = (OFW'(of_level) + OFW'(valid_s1)) < OFW'(adl_pkg::OUT_FIFO_DEPTH);
		issue  = active_q && room;
		at_end = idx_q == len_q;
		mem_raddr = {bank_q, idx_q};
		rel.valid = issue && at_end;
		rel.bank  = bank_q;
		of_din = {nl_s1 ? adl_pkg::NEWLINE : mem_rdata, cnt_s1, nl_s1};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			valid_s1 <= 1'b0;
		end else begin
			if (rq_pop) begin
				active_q <= 1'b1;
			end else if (issue && at_end) begin
				active_q <= 1'b0;
			end
			valid_s1 <= issue;
		end
	end

	always_ff @(posedge clk) begin
		if (rq_pop) begin
			bank_q <= rq_bank;
			len_q  <= rq_len;
			cnt_q  <= rq_count;
			idx_q  <= '0;
		end else if (issue && !at_end) begin
			idx_q <= idx_q + LW'(1);
		end
		nl_s1  <= at_end;
		cnt_s1 <= cnt_q;
	end

	adl_fifo #(
		.WIDTH(adl_pkg::OUT_W),
		.DEPTH(adl_pkg::OUT_FIFO_DEPTH)
	) u_out_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (valid_s1),
		.din   (of_din),
		.full  (of_full),
		.pop   (pop),
		.dout  (of_dout),
		.empty (empty),
		.level (of_level)
	);

	assign {out_byte, run_count, line_end} = of_dout;

endmodule

// ----- rtl/adjacent_line_dedup.sv -----
// Top level of the adjacent duplicate line filter: configuration registers,
// line buffer, front end, run queue and back end. Depends on adl_pkg and all rtl/ modules.
//
//  channel  | direction | handshake             | payload
//  ---------+-----------+-----------------------+-----------------------------------
//  input    | in        | push / full           | operation, data_byte
//  results  | out       | pop / empty           | out_byte, run_count, line_end
//  config   | in        | cfg_we (no wait)      | cfg_index, cfg_data
//
// A byte that joins a line is written to the line buffer while the byte at the same place
// of the previous line is read, and the compare uses the registered read data. Results
// leave at one per cycle while pop is held and the result queue is not empty; the back end
// takes a run of an n-byte line from the run queue and then reads out its n bytes and the
// newline. Input stalls while the run queue is full or the front end compares or flushes.
// Reset is asynchronous; there is no clearing pass.
module adjacent_line_dedup #(
	parameter int LINE_MAX = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            push,
	output logic                            full,
	input  logic                            operation,
	input  logic [7:0]                      data_byte,
	output logic                            empty,
	input  logic                            pop,
	output logic [7:0]                      out_byte,
	output logic [adl_pkg::COUNT_W-1:0]     run_count,
	output logic                            line_end,
	input  logic                            cfg_we,
	input  logic [adl_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic                            cfg_data
);

	localparam int LW        = $clog2(LINE_MAX);
	localparam int AW        = adl_pkg::BANK_W + LW;
	localparam int MEM_DEPTH = adl_pkg::NUM_BANKS * (2 ** LW);
	localparam int RQ_W      = adl_pkg::BANK_W + LW + adl_pkg::COUNT_W;

	adl_pkg::adl_cfg_t     cfg_q;
	adl_pkg::adl_release_t rel;

	logic                        mem_we;
	logic [AW-1:0]               mem_waddr;
	logic [7:0]                  mem_wdata;
	logic [AW-1:0]               raddr_a;
	logic [7:0]                  rdata_a;
	logic [AW-1:0]               raddr_b;
	logic [7:0]                  rdata_b;

	logic                        rq_push;
	logic                        rq_full;
	logic                        rq_pop;
	logic                        rq_empty;
	logic [adl_pkg::BANK_W-1:0]  rqi_bank;
	logic [LW-1:0]               rqi_len;
	logic [adl_pkg::COUNT_W-1:0] rqi_count;
	logic [adl_pkg::BANK_W-1:0]  rqo_bank;
	logic [LW-1:0]               rqo_len;
	logic [adl_pkg::COUNT_W-1:0] rqo_count;
	logic [RQ_W-1:0]             rq_din;
	logic [RQ_W-1:0]             rq_dout;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				adl_pkg::REG_ONLY_REPEATED: cfg_q.only_repeated <= cfg_data;
				adl_pkg::REG_ONLY_SINGLE:   cfg_q.only_single   <= cfg_data;
				adl_pkg::REG_SHOW_COUNT:    cfg_q.show_count    <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign mem_wdata = data_byte;

	adl_linebuf #(
		.AW   (AW),
		.DEPTH(MEM_DEPTH)
	) u_linebuf (
		.clk    (clk),
		.we     (mem_we),
		.waddr  (mem_waddr),
		.wdata  (mem_wdata),
		.raddr_a(raddr_a),
		.rdata_a(rdata_a),
		.raddr_b(raddr_b),
		.rdata_b(rdata_b)
	);

	adl_front #(
		.LINE_MAX(LINE_MAX)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.operation(operation),
		.data_byte(data_byte),
		.cfg      (cfg_q),
		.mem_we   (mem_we),
		.mem_waddr(mem_waddr),
		.mem_raddr(raddr_a),
		.mem_rdata(rdata_a),
		.rq_push  (rq_push),
		.rq_full  (rq_full),
		.rq_bank  (rqi_bank),
		.rq_len   (rqi_len),
		.rq_count (rqi_count),
		.rel      (rel)
	);

	assign rq_din = {rqi_bank, rqi_len, rqi_count};
	assign {rqo_bank, rqo_len, rqo_count} = rq_dout;

	adl_fifo #(
		.WIDTH(RQ_W),
		.DEPTH(adl_pkg::RUN_QUEUE_DEPTH)
	) u_run_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (rq_push),
		.din   (rq_din),
		.full  (rq_full),
		.pop   (rq_pop),
		.dout  (rq_dout),
		.empty (rq_empty),
		.level ()
	);

	adl_back #(
		.LINE_MAX(LINE_MAX)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.rq_empty (rq_empty),
		.rq_pop   (rq_pop),
		.rq_bank  (rqo_bank),
		.rq_len   (rqo_len),
		.rq_count (rqo_count),
		.mem_raddr(raddr_b),
		.mem_rdata(rdata_b),
		.rel      (rel),
		.empty    (empty),
		.pop      (pop),
		.out_byte (out_byte),
		.run_count(run_count),
		.line_end (line_end)
	);

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for adjacent_line_dedup: directed rows, then random text in
// several filter settings, each result checked against a line-level uniq predictor or a typed row.
// Depends on adl_pkg and the rtl/ sources of the block.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LINE_MAX = 32;
	localparam int PHASE_ITEMS = 28;
	localparam int QUIET_CYCLES = 2 * LINE_MAX + 16;

	localparam bit OP_DATA = 1'b0;
	localparam bit OP_FLUSH = 1'b1;
	// Index past the register list; writes there must change nothing.
	localparam logic [adl_pkg::CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;

	typedef struct {
		logic [7:0]  ch;
		logic [31:0] count;
		logic        last;
	} out_char_t;

	typedef enum {ROW_PREDICT, ROW_SILENT, ROW_ONE_RESULT} row_kind_t;

	typedef struct {
		bit         op;
		logic [7:0] data;
		row_kind_t  kind;
		out_char_t  typed;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic full;
	logic operation = 1'b0;
	logic [7:0] data_byte = 8'h00;
	logic empty;
	logic pop = 1'b0;
	logic [7:0] out_byte;
	logic [adl_pkg::COUNT_W-1:0] run_count;
	logic line_end;
	logic cfg_we = 1'b0;
	logic [adl_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
	logic cfg_data = 1'b0;

	adjacent_line_dedup #(.LINE_MAX(LINE_MAX)) uut (
		.clk(clk), .arst_n(arst_n),
		.push(push), .full(full), .operation(operation), .data_byte(data_byte),
		.empty(empty), .pop(pop), .out_byte(out_byte), .run_count(run_count),
		.line_end(line_end),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #4 clk = ~clk;

	initial begin
		#30_000_000;
		$display("[adjacent_line_dedup] ERROR");
		$finish;
	end

	// Predictor state: the line being built, the line of the open run, and its count.
	logic [7:0] cur_line [LINE_MAX];
	logic [7:0] prev_line [LINE_MAX];
	int unsigned cur_len = 0;
	int unsigned prev_len = 0;
	bit prev_valid = 1'b0;
	logic [31:0] run_len = '0;
	adl_pkg::adl_cfg_t cfg_model = '0;

	out_char_t step_out[$];
	out_char_t out_chars_due[$];

	int errors = 0;
	int items_sent = 0;
	int chars_checked = 0;
	int lines_checked = 0;
	int phases_run = 0;
	bit sender_steady = 1'b0;

	function void append_run();
		logic [31:0] cnt;
		if (!prev_valid)
			return;
		if (cfg_model.only_repeated && run_len < 2)
			return;
		if (cfg_model.only_single && run_len > 1)
			return;
		cnt = cfg_model.show_count ? run_len : 32'd0;
		for (int i = 0; i < prev_len; i++)
			step_out.push_back('{prev_line[i], cnt, 1'b0});
		step_out.push_back('{adl_pkg::NEWLINE, cnt, 1'b1});
	endfunction

	function void close_line_model();
		bit same;
		same = prev_valid && prev_len == cur_len;
		for (int i = 0; i < cur_len; i++)
			if (prev_line[i] != cur_line[i])
				same = 1'b0;
		if (!same) begin
			append_run();
			for (int i = 0; i < cur_len; i++)
				prev_line[i] = cur_line[i];
			prev_len = cur_len;
			prev_valid = 1'b1;
			run_len = 32'd1;
		end else if (run_len != 32'hFFFF_FFFF) begin
			run_len++;
		end
		cur_len = 0;
	endfunction

	function void dedup_step(bit op, logic [7:0] b);
		step_out.delete();
		if (op == OP_FLUSH) begin
			if (cur_len > 0)
				close_line_model();
			append_run();
			cur_len = 0;
			prev_len = 0;
			prev_valid = 1'b0;
			run_len = '0;
		end else if (b == adl_pkg::NEWLINE || cur_len + 1 >= LINE_MAX) begin
			close_line_model();
			if (b != adl_pkg::NEWLINE) begin
				cur_line[0] = b;
				cur_len = 1;
			end
		end else begin
			cur_line[cur_len] = b;
			cur_len++;
		end
	endfunction

	// Result side: every popped transaction is matched against the oldest expectation.
	always @(posedge clk) begin
		out_char_t want;
		if (arst_n && pop && !empty) begin
			if (out_chars_due.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, expected none, got %02h/%0d/%0b",
					$time, out_byte, run_count, line_end);
			end else begin
				want = out_chars_due.pop_front();
				chars_checked++;
				if (line_end)
					lines_checked++;
				if (out_byte !== want.ch || run_count !== want.count ||
					line_end !== want.last) begin
					errors++;
					$display("%0t: mismatch (byte/count/last), expected %02h/%0d/%0b, got %02h/%0d/%0b",
						$time, want.ch, want.count, want.last, out_byte, run_count, line_end);
				end
			end
		end
	end

	// Pop pattern: mostly short stalls, a few long ones, and stretches of none at all.
	initial begin
		int stall_left;
		int cycle_cnt;
		bit steady;
		int r;
		stall_left = 0;
		cycle_cnt = 0;
		steady = 1'b0;
		forever begin
			@(negedge clk);
			cycle_cnt++;
			if (cycle_cnt % 300 == 0)
				steady = ($urandom_range(0, 2) == 0);
			if (stall_left > 0) begin
				pop <= 1'b0;
				stall_left--;
			end else begin
				pop <= 1'b1;
				if (!steady) begin
					r = $urandom_range(0, 99);
					if (r < 75)
						stall_left = 0;
					else if (r < 93)
						stall_left = $urandom_range(1, 3);
					else
						stall_left = $urandom_range(10, 24);
				end
			end
		end
	end

	function int pick_gap();
		int r;
		if (sender_steady)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 24);
	endfunction

	// Called at a falling edge; returns at the falling edge after the transaction,
	// with the predicted results of the item in step_out.
	task automatic send_item(input bit op, input logic [7:0] b, input bit use_model);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		push <= 1'b1;
		operation <= op;
		data_byte <= b;
		do
			@(posedge clk);
		while (full);
		@(negedge clk);
		items_sent++;
		dedup_step(op, b);
		if (use_model)
			foreach (step_out[i])
				out_chars_due.push_back(step_out[i]);
	endtask

	task automatic drain(input int quiet);
		push <= 1'b0;
		while (out_chars_due.size() != 0)
			@(posedge clk);
		repeat (quiet) @(posedge clk);
		@(negedge clk);
	endtask

	// Writes all three registers back to back, plus a junk write to the unused index if poke_unused.
	task automatic set_config(input adl_pkg::adl_cfg_t c, input bit poke_unused);
		cfg_we <= 1'b1;
		cfg_index <= adl_pkg::REG_ONLY_REPEATED;
		cfg_data <= c.only_repeated;
		@(negedge clk);
		cfg_index <= adl_pkg::REG_ONLY_SINGLE;
		cfg_data <= c.only_single;
		@(negedge clk);
		cfg_index <= adl_pkg::REG_SHOW_COUNT;
		cfg_data <= c.show_count;
		@(negedge clk);
		if (poke_unused) begin
			cfg_index <= REG_UNUSED;
			cfg_data <= 1'($urandom_range(0, 1));
			@(negedge clk);
		end
		cfg_we <= 1'b0;
		cfg_model = c;
		@(negedge clk);
	endtask

	function logic [7:0] rand_char();
		logic [7:0] c;
		case ($urandom_range(0, 3))
			0: c = 8'h00;
			1: c = 8'hFF;
			2: c = 8'h61 + 8'($urandom_range(0, 1));
			default: c = 8'($urandom_range(0, 255));
		endcase
		if (c == adl_pkg::NEWLINE)
			c = 8'h0B;
		return c;
	endfunction

	logic [7:0] last_text[$];

	// Sends one line of text; half the lines repeat or nearly repeat the last one so that
	// runs form, and a few end in a flush instead of a newline.
	task automatic send_random_line();
		logic [7:0] text[$];
		int r;
		int len;
		if ($urandom_range(0, 9) == 0)
			sender_steady = ~sender_steady;
		if ($urandom_range(0, 39) == 0)
			drain(0);
		r = $urandom_range(0, 99);
		if (r < 40) begin
			text = last_text;
		end else if (r < 50) begin
			text = last_text;
			if (text.size() > 0)
				text[$urandom_range(0, text.size() - 1)] = rand_char();
			else
				text.push_back(rand_char());
		end else if (r < 60) begin
			text.delete();
		end else begin
			len = (r < 68) ? $urandom_range(28, 40) : $urandom_range(1, 8);
			for (int i = 0; i < len; i++)
				text.push_back(rand_char());
		end
		last_text = text;
		foreach (text[i])
			send_item(OP_DATA, text[i], 1'b1);
		if ($urandom_range(0, 19) == 0)
			send_item(OP_FLUSH, 8'($urandom_range(0, 255)), 1'b1);
		else
			send_item(OP_DATA, adl_pkg::NEWLINE, 1'b1);
	endtask

	stim_row_t directed_rows [19] = '{
		'{OP_FLUSH, 8'hFF, ROW_SILENT,     '{8'h00, 32'd0, 1'b0}},
		'{OP_DATA,  8'h41, ROW_SILENT,     '{8'h00, 32'd0, 1'b0}},
		'{OP_DATA,  8'h0A, ROW_SILENT,     '{8'h00, 32'd0, 1'b0}},
		'{OP_DATA,  8'h0A, ROW_PREDICT,    '{8'h00, 32'd0, 1'b0}},
		'{OP_DATA,  8'h0A, ROW_SILENT,     '{8'h00, 32'd0, 1'b0}},
		'{OP_DATA,  8'h00, ROW_SILENT,     '{8'h00, 32'd0, 1'b0}},
		'{OP_DATA,  8'hFF, ROW_SILENT,     '{8'h00, 32'd0, 1'b0}},
		'{OP_DATA,  8'h0A, ROW_ONE_RESULT, '{8'h0A, 32'd2, 1'b1}},
		'{OP_DATA,  8'h00, ROW_SILENT,     '{8'h00, 32'd0, 1'b0}},
		'{OP_DATA,  8'hFF, ROW_SILENT,     '{8'h00, 32'd0, 1'b0}},
		'{OP_DATA,  8'h0A, ROW_SILENT,     '{8'h00, 32'd0, 1'b0}},
		'{OP_FLUSH, 8'h00, ROW_PREDICT,    '{8'h00, 32'd0, 1'b0}},
		'{OP_DATA,  8'h42, ROW_SILENT,     '{8'h00, 32'd0, 1'b0}},
		'{OP_DATA,  8'h0A, ROW_SILENT,     '{8'h00, 32'd0, 1'b0}},
		'{OP_DATA,  8'h43, ROW_SILENT,     '{8'h00, 32'd0, 1'b0}},
		'{OP_FLUSH, 8'h0A, ROW_PREDICT,    '{8'h00, 32'd0, 1'b0}},
		'{OP_FLUSH, 8'h55, ROW_SILENT,     '{8'h00, 32'd0, 1'b0}},
		'{OP_DATA,  8'h0A, ROW_SILENT,     '{8'h00, 32'd0, 1'b0}},
		'{OP_FLUSH, 8'hA5, ROW_ONE_RESULT, '{8'h0A, 32'd1, 1'b1}}
	};

	// Filter settings per random phase; both filters together must silence everything.
	adl_pkg::adl_cfg_t phase_cfgs [9] = '{
		'{1'b0, 1'b0, 1'b0}, '{1'b0, 1'b0, 1'b1}, '{1'b1, 1'b0, 1'b1},
		'{1'b0, 1'b1, 1'b1}, '{1'b1, 1'b1, 1'b1}, '{1'b1, 1'b0, 1'b0},
		'{1'b0, 1'b1, 1'b0}, '{1'b1, 1'b1, 1'b0}, '{1'b0, 1'b0, 1'b1}
	};

	initial begin
		int phase_base;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		set_config('{1'b0, 1'b0, 1'b1}, 1'b1);
		foreach (directed_rows[i]) begin
			send_item(directed_rows[i].op, directed_rows[i].data,
				directed_rows[i].kind == ROW_PREDICT);
			if (directed_rows[i].kind == ROW_ONE_RESULT)
				out_chars_due.push_back(directed_rows[i].typed);
		end
		drain(QUIET_CYCLES);

		foreach (phase_cfgs[p]) begin
			set_config(phase_cfgs[p], 1'(p % 2));
			phases_run++;
			phase_base = items_sent;
			while (items_sent - phase_base < PHASE_ITEMS)
				send_random_line();
			send_item(OP_FLUSH, 8'($urandom_range(0, 255)), 1'b1);
			drain(QUIET_CYCLES);
		end

		drain(100);
		$display("Sent %0d input items over the directed rows and %0d filter settings.",
			items_sent, phases_run);
		$display("Checked %0d output bytes closing %0d emitted lines.",
			chars_checked, lines_checked);
		if (errors == 0)
			$display("[adjacent_line_dedup] OK");
		else
			$display("[adjacent_line_dedup] ERROR");
		$finish;
	end

endmodule
